/* design/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants of the token pipeline step block.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int REG_COUNT_DEF   = 16;
	localparam int MEM_WORDS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int DATA_WIDTH_DEF  = 32;

	typedef enum logic [1:0] {
		KIND_STEP     = 2'd0,
		KIND_INSTR    = 2'd1,
		KIND_LOAD_REG = 2'd2,
		KIND_LOAD_MEM = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_ST  = 2'd3
	} opcode_t;

	typedef struct packed {
		kind_t              kind;
		opcode_t            opcode;
		logic [3:0]         dest_reg;
		logic [3:0]         src1_reg;
		logic [3:0]         src2_reg;
		logic signed [15:0] store_offset;
		logic [3:0]         load_index;
		logic signed [31:0] load_value;
	} step_in_t;

	typedef struct packed {
		logic               reg_write_valid;
		logic [3:0]         reg_write_index;
		logic signed [31:0] reg_write_value;
		logic               mem_write_valid;
		logic [3:0]         mem_write_addr;
		logic signed [31:0] mem_write_value;
		logic               pipeline_empty;
		logic               queue_overflow;
	} step_out_t;

endpackage

/* design/tpc_chan_if.sv */
// ----------------------------------------------------------------------------
// tpc_chan_if
// Valid/ready channel that carries one item of payload type T.
// ----------------------------------------------------------------------------
interface tpc_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/tpc_ram.sv */
// ----------------------------------------------------------------------------
// tpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* design/token_pipeline_cpu_step.sv */
// ----------------------------------------------------------------------------
// token_pipeline_cpu_step
// In-order ADD/SUB/MUL/ST pipeline advanced by one stage per step item.
// ----------------------------------------------------------------------------
// Each accepted item is held in the accept stage, then its result is registered.
// Throughput: one item per cycle unless the response stalls; register reads go to
// RAM copies at acceptance and the write of the previous item is forwarded.
// Reset clears all stage valid bits, the result queue count and the register valid
// bits, so the register file reads as zero until written.
module token_pipeline_cpu_step #(
	parameter int REG_COUNT   = tpc_pkg::REG_COUNT_DEF,
	parameter int MEM_WORDS   = tpc_pkg::MEM_WORDS_DEF,
	parameter int QUEUE_DEPTH = tpc_pkg::QUEUE_DEPTH_DEF,
	parameter int DATA_WIDTH  = tpc_pkg::DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	tpc_chan_if.sink   req,
	tpc_chan_if.source rsp
);
	import tpc_pkg::*;

	localparam int DW  = DATA_WIDTH;
	localparam int AW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int QPW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam longint RECIP_L = (64'd1 << 32) / MEM_WORDS;
	localparam logic [31:0] RECIP = 32'(RECIP_L);
	localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);

	function automatic logic in_rng(input logic [3:0] idx);
		return 6'(idx) < 6'(REG_COUNT);
	endfunction

	function automatic logic [QPW-1:0] qwrap(input logic [QPW:0] v);
		return (v >= (QPW+1)'(QUEUE_DEPTH)) ? QPW'(v - (QPW+1)'(QUEUE_DEPTH)) : QPW'(v);
	endfunction

	// Accept stage.
	logic     s1_vld_q;
	step_in_t item_s1;
	logic     fwd_s1;
	logic [3:0] idx_s1 [3];
	logic     proc, accept, is_step;

	// Output register.
	logic      rsp_vld_q;
	step_out_t rsp_q;

	// Pipeline slots.
	logic dec_vld_q, alu_vld_q, sis_vld_q, mul_vld_q, adr_vld_q;
	opcode_t dec_op_q, alu_op_q;
	logic [3:0] dec_rd_q, alu_rd_q, sis_rd_q, mul_rd_q, adr_rd_q;
	logic [DW-1:0] dec_a_q, dec_b_q, alu_a_q, alu_b_q, mul_a_q, mul_b_q;
	logic [DW-1:0] sis_sum_q, adr_sum_q;
	logic [31:0]   adr_quot_q;

	// Result queue.
	logic [3:0]     q_reg_q [QUEUE_DEPTH];
	logic [DW-1:0]  q_val_q [QUEUE_DEPTH];
	logic [QPW-1:0] head_q;
	logic [QCW-1:0] cnt_q;

	// Register file bookkeeping.
	logic [REG_COUNT-1:0] rvld_q;
	logic          lw_we_q;
	logic [3:0]    lw_idx_q;
	logic [DW-1:0] lw_data_q;
	logic [DW-1:0] ram_q [3];
	logic [3:0]    rd_idx [3];
	logic [DW-1:0] rv [3];

	// Step logic.
	logic          pop, hd_we, rf_we;
	logic [3:0]    hd_reg, rf_widx;
	logic [DW-1:0] hd_val, rf_wdata;
	logic [QPW-1:0] head_n, t0, t1;
	logic [QCW-1:0] c0, c1, cnt_n;
	logic          push0, push1, ok0, ok1, dropped;
	logic [DW-1:0] prod, alu_res, off_dw;
	logic [31:0]   sum32, rem, rem_c, quot_n;
	logic [63:0]   qprod;
	logic [31:0]   off32;
	logic          empty_n;
	step_out_t     out_n;

	assign is_step = (item_s1.kind == KIND_STEP) || (item_s1.kind == KIND_INSTR);
	assign proc    = s1_vld_q && (!rsp_vld_q || rsp.ready);
	assign accept  = req.valid && req.ready;
	assign req.ready = !s1_vld_q || proc;
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	assign rd_idx[0] = req.data.src1_reg;
	assign rd_idx[1] = req.data.src2_reg;
	assign rd_idx[2] = (proc && is_step) ? sis_rd_q : adr_rd_q;

	for (genvar g = 0; g < 3; g++) begin : g_rf
		tpc_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_rf (
			.clk   (clk),
			.we    (rf_we),
			.waddr (AW'(rf_widx)),
			.wdata (rf_wdata),
			.re    (accept),
			.raddr (AW'(rd_idx[g])),
			.rdata (ram_q[g])
		);
	end

	always_comb begin
		hd_reg = q_reg_q[head_q];
		hd_val = q_val_q[head_q];
		pop    = is_step && (cnt_q != '0);
		hd_we  = pop && in_rng(hd_reg);
		for (int j = 0; j < 3; j++) begin
			if (hd_we && hd_reg == idx_s1[j]) begin
				rv[j] = hd_val;
			end else if (fwd_s1 && lw_we_q && lw_idx_q == idx_s1[j]) begin
				rv[j] = lw_data_q;
			end else if (in_rng(idx_s1[j]) && rvld_q[AW'(idx_s1[j])]) begin
				rv[j] = ram_q[j];
			end else begin
				rv[j] = '0;
			end
		end
		rf_we    = proc && (hd_we || (item_s1.kind == KIND_LOAD_REG && in_rng(item_s1.load_index)));
		rf_widx  = hd_we ? hd_reg : item_s1.load_index;
		rf_wdata = hd_we ? hd_val : DW'(item_s1.load_value);

		head_n = pop ? qwrap((QPW+1)'(head_q) + 1'b1) : head_q;
		c0     = pop ? cnt_q - 1'b1 : cnt_q;
		push0  = mul_vld_q;
		push1  = alu_vld_q && (alu_op_q == OP_ADD || alu_op_q == OP_SUB);
		ok0    = push0 && (c0 != QFULL);
		c1     = ok0 ? c0 + 1'b1 : c0;
		ok1    = push1 && (c1 != QFULL);
		cnt_n  = ok1 ? c1 + 1'b1 : c1;
		dropped = (push0 && !ok0) || (push1 && !ok1);
		t0     = qwrap((QPW+1)'(head_n) + (QPW+1)'(c0));
		t1     = qwrap((QPW+1)'(head_n) + (QPW+1)'(c1));
		prod   = DW'(mul_a_q * mul_b_q);
		alu_res = (alu_op_q == OP_SUB) ? DW'(alu_a_q - alu_b_q) : DW'(alu_a_q + alu_b_q);

		qprod  = 64'(32'(sis_sum_q)) * 64'(RECIP);
		quot_n = qprod[63:32];
		sum32  = 32'(adr_sum_q);
		rem    = sum32 - 32'(adr_quot_q * 32'(MEM_WORDS));
		rem_c  = (rem >= 32'(MEM_WORDS)) ? rem - 32'(MEM_WORDS) : rem;

		off32  = 32'(item_s1.store_offset);
		off_dw = DW'(off32);

		empty_n = !(item_s1.kind == KIND_INSTR) && !dec_vld_q && !sis_vld_q
			&& !(alu_vld_q && alu_op_q == OP_MUL) && (cnt_n == '0);

		out_n = '0;
		if (is_step) begin
			out_n.reg_write_valid = pop;
			out_n.reg_write_index = pop ? hd_reg : 4'd0;
			out_n.reg_write_value = pop ? 32'(signed'(hd_val)) : 32'sd0;
			out_n.mem_write_valid = adr_vld_q;
			out_n.mem_write_addr  = adr_vld_q ? 4'(rem_c) : 4'd0;
			out_n.mem_write_value = adr_vld_q ? 32'(signed'(rv[2])) : 32'sd0;
			out_n.pipeline_empty  = empty_n;
			out_n.queue_overflow  = dropped;
		end else begin
			out_n.pipeline_empty = !dec_vld_q && !alu_vld_q && !sis_vld_q && !mul_vld_q
				&& !adr_vld_q && (cnt_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			rsp_vld_q <= 1'b0;
			dec_vld_q <= 1'b0;
			alu_vld_q <= 1'b0;
			sis_vld_q <= 1'b0;
			mul_vld_q <= 1'b0;
			adr_vld_q <= 1'b0;
			head_q    <= '0;
			cnt_q     <= '0;
			rvld_q    <= '0;
			lw_we_q   <= 1'b0;
		end else begin
			if (accept) begin
				s1_vld_q <= 1'b1;
			end else if (proc) begin
				s1_vld_q <= 1'b0;
			end
			if (proc) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (proc) begin
				lw_we_q <= rf_we;
				if (rf_we) begin
					rvld_q[AW'(rf_widx)] <= 1'b1;
				end
			end
			if (proc && is_step) begin
				head_q    <= head_n;
				cnt_q     <= cnt_n;
				mul_vld_q <= alu_vld_q && alu_op_q == OP_MUL;
				alu_vld_q <= dec_vld_q && dec_op_q != OP_ST;
				adr_vld_q <= sis_vld_q;
				sis_vld_q <= dec_vld_q && dec_op_q == OP_ST;
				dec_vld_q <= item_s1.kind == KIND_INSTR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req.data;
			fwd_s1  <= proc;
			for (int j = 0; j < 3; j++) begin
				idx_s1[j] <= rd_idx[j];
			end
		end
		if (proc) begin
			rsp_q     <= out_n;
			lw_idx_q  <= rf_widx;
			lw_data_q <= rf_wdata;
		end
		if (proc && is_step) begin
			for (int e = 0; e < QUEUE_DEPTH; e++) begin
				if (ok0 && QPW'(e) == t0) begin
					q_reg_q[e] <= mul_rd_q;
					q_val_q[e] <= prod;
				end else if (ok1 && QPW'(e) == t1) begin
					q_reg_q[e] <= alu_rd_q;
					q_val_q[e] <= alu_res;
				end
			end
			mul_rd_q   <= alu_rd_q;
			mul_a_q    <= alu_a_q;
			mul_b_q    <= alu_b_q;
			adr_rd_q   <= sis_rd_q;
			adr_sum_q  <= sis_sum_q;
			adr_quot_q <= quot_n;
			sis_rd_q   <= dec_rd_q;
			sis_sum_q  <= DW'(dec_a_q + dec_b_q);
			alu_op_q   <= dec_op_q;
			alu_rd_q   <= dec_rd_q;
			alu_a_q    <= dec_a_q;
			alu_b_q    <= dec_b_q;
			dec_op_q   <= item_s1.opcode;
			dec_rd_q   <= item_s1.dest_reg;
			dec_a_q    <= rv[0];
			dec_b_q    <= (item_s1.opcode == OP_ST) ? off_dw : rv[1];
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QFULL)
		else $error("result queue count beyond depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		proc && is_step && dropped |=> cnt_q == QFULL)
		else $error("result dropped while queue had room");

	a_load_hold: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !is_step |=> cnt_q == $past(cnt_q) && head_q == $past(head_q))
		else $error("preload item moved the result queue");

	a_mem_addr: assert property (@(posedge clk) disable iff (!arst_n)
		proc && is_step && adr_vld_q |-> rem_c < 32'(MEM_WORDS))
		else $error("store address out of range");
endmodule

/* test/token_pipeline_cpu_step_sb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_pipeline_cpu_step_sb
// Pipeline step predictor and result checker for the token pipeline block.
// Every accepted step item advances a private copy of the pipeline state, and
// each response item is compared as a whole with the oldest prediction.
// ----------------------------------------------------------------------------
import tpc_pkg::*;

class pipe_step_scoreboard;
	logic        dec_v;
	opcode_t     dec_op;
	logic [3:0]  dec_rd;
	logic [31:0] dec_a, dec_b;
	logic        alu_v;
	opcode_t     alu_op;
	logic [3:0]  alu_rd;
	logic [31:0] alu_a, alu_b;
	logic        sti_v;
	logic [3:0]  sti_rs;
	logic [31:0] sti_base, sti_imm;
	logic        mul_v;
	logic [3:0]  mul_rd;
	logic [31:0] mul_a, mul_b;
	logic        adr_v;
	logic [3:0]  adr_rs;
	logic [31:0] adr_val;
	logic [35:0] res_q[$];
	logic [31:0] regs[16];
	logic [31:0] mem[16];
	step_out_t   pending[$];
	int          errors;

	function new();
		dec_v = 0; alu_v = 0; sti_v = 0; mul_v = 0; adr_v = 0;
		dec_a = 0; dec_b = 0; alu_a = 0; alu_b = 0;
		dec_op = OP_ADD; alu_op = OP_ADD;
		dec_rd = 0; alu_rd = 0; sti_rs = 0; mul_rd = 0; adr_rs = 0;
		sti_base = 0; sti_imm = 0; mul_a = 0; mul_b = 0; adr_val = 0;
		foreach (regs[i]) regs[i] = 0;
		foreach (mem[i]) mem[i] = 0;
		errors = 0;
	endfunction

	function void queue_result(logic [3:0] rd, logic [31:0] v, ref logic drop);
		if (res_q.size() < 4)
			res_q.insert(res_q.size(), {rd, v});
		else
			drop = 1;
	endfunction

	function void note_step(step_in_t s);
		step_out_t o;
		logic drop;
		logic [35:0] e;
		o = '0;
		drop = 0;
		if (s.kind == KIND_LOAD_REG) begin
			regs[s.load_index] = s.load_value;
		end else if (s.kind == KIND_LOAD_MEM) begin
			mem[s.load_index] = s.load_value;
		end else begin
			if (res_q.size() > 0) begin
				e = res_q[0];
				res_q.delete(0);
				regs[e[35:32]] = e[31:0];
				o.reg_write_valid = 1;
				o.reg_write_index = e[35:32];
				o.reg_write_value = e[31:0];
			end
			if (mul_v) begin
				queue_result(mul_rd, mul_a * mul_b, drop);
				mul_v = 0;
			end
			if (alu_v) begin
				if (alu_op == OP_MUL) begin
					mul_v = 1; mul_rd = alu_rd; mul_a = alu_a; mul_b = alu_b;
				end else if (alu_op == OP_ADD) begin
					queue_result(alu_rd, alu_a + alu_b, drop);
				end else if (alu_op == OP_SUB) begin
					queue_result(alu_rd, alu_a - alu_b, drop);
				end
				alu_v = 0;
			end
			if (adr_v) begin
				mem[adr_val[3:0]] = regs[adr_rs];
				o.mem_write_valid = 1;
				o.mem_write_addr = adr_val[3:0];
				o.mem_write_value = regs[adr_rs];
				adr_v = 0;
			end
			if (sti_v) begin
				adr_v = 1; adr_rs = sti_rs; adr_val = sti_base + sti_imm;
				sti_v = 0;
			end
			if (dec_v) begin
				if (dec_op == OP_ST) begin
					sti_v = 1; sti_rs = dec_rd; sti_base = dec_a; sti_imm = dec_b;
				end else begin
					alu_v = 1; alu_op = dec_op; alu_rd = dec_rd; alu_a = dec_a; alu_b = dec_b;
				end
				dec_v = 0;
			end
			if (s.kind == KIND_INSTR) begin
				dec_v = 1;
				dec_op = s.opcode;
				dec_rd = s.dest_reg;
				dec_a = regs[s.src1_reg];
				dec_b = (s.opcode == OP_ST) ? {{16{s.store_offset[15]}}, s.store_offset}
					: regs[s.src2_reg];
			end
		end
		o.pipeline_empty = !dec_v && !alu_v && !sti_v && !mul_v && !adr_v && res_q.size() == 0;
		o.queue_overflow = drop;
		pending.insert(pending.size(), o);
	endfunction

	function void check_result(step_out_t got);
		step_out_t exp;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		exp = pending[0];
		pending.delete(0);
		if (got !== exp)
			$display("%0t: result mismatch, expected %h, actual %h", $time, exp, got);
		if (got !== exp)
			errors++;
	endfunction
endclass

/* test/token_pipeline_cpu_step_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_pipeline_cpu_step_test
// Self-checking bench for the token pipeline step block.
// Directed corner items are followed by random instruction streams with
// preloads, random gaps on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module token_pipeline_cpu_step_test;
	import tpc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	bit   stim_done = 0;
	bit   hold_off = 0;
	int   rsp_gap_pct = 13;
	int   req_gap_pct = 13;

	tpc_chan_if #(.T(step_in_t))  req ();
	tpc_chan_if #(.T(step_out_t)) rsp ();

	token_pipeline_cpu_step DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	pipe_step_scoreboard sb = new();

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	task automatic send_step(step_in_t s);
		req.valid <= 1;
		req.data <= s;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_step(s);
		while ($urandom_range(99) < req_gap_pct) begin
			req.valid <= 0;
			@(posedge clk);
		end
	endtask

	function automatic step_in_t rand_step();
		step_in_t s;
		int r;
		s = '0;
		r = $urandom_range(99);
		if (r < 12)
			s.kind = KIND_STEP;
		else if (r < 80)
			s.kind = KIND_INSTR;
		else if (r < 92)
			s.kind = KIND_LOAD_REG;
		else
			s.kind = KIND_LOAD_MEM;
		s.opcode = opcode_t'($urandom_range(3));
		s.dest_reg = 4'($urandom);
		s.src1_reg = 4'($urandom);
		s.src2_reg = 4'($urandom);
		s.store_offset = 16'($urandom);
		s.load_index = 4'($urandom);
		s.load_value = $urandom;
		if ($urandom_range(3) == 0)
			s.load_value = $urandom_range(3) == 0 ? 32'h7fffffff : 32'h80000000;
		return s;
	endfunction

	function automatic step_in_t mk(kind_t k, opcode_t op, int rd, int r1, int r2,
		int offs, int li, int lv);
		step_in_t s;
		s.kind = k; s.opcode = op; s.dest_reg = 4'(rd); s.src1_reg = 4'(r1);
		s.src2_reg = 4'(r2); s.store_offset = 16'(offs); s.load_index = 4'(li);
		s.load_value = lv;
		return s;
	endfunction

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			sb.check_result(rsp.data);
		rsp.ready <= arst_n && !hold_off && ($urandom_range(99) >= rsp_gap_pct);
	end

	initial begin
		int n;
		req.valid = 0;
		req.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_step(mk(KIND_LOAD_REG, OP_ADD, 0, 0, 0, 0, 0, 32'h7fffffff));
		send_step(mk(KIND_LOAD_REG, OP_ADD, 0, 0, 0, 0, 15, 32'h80000000));
		send_step(mk(KIND_LOAD_REG, OP_ADD, 0, 0, 0, 0, 1, -1));
		send_step(mk(KIND_LOAD_MEM, OP_ADD, 0, 0, 0, 0, 15, 32'h12345678));
		send_step(mk(KIND_INSTR, OP_ADD, 2, 0, 15, 0, 0, 0));
		send_step(mk(KIND_INSTR, OP_SUB, 3, 15, 0, 0, 0, 0));
		send_step(mk(KIND_INSTR, OP_MUL, 4, 0, 1, 0, 0, 0));
		send_step(mk(KIND_INSTR, OP_ST, 0, 1, 0, 32767, 0, 0));
		send_step(mk(KIND_INSTR, OP_ST, 15, 15, 0, -32768, 0, 0));
		send_step(mk(KIND_INSTR, OP_MUL, 5, 15, 15, 0, 0, 0));
		send_step(mk(KIND_INSTR, OP_ADD, 6, 1, 1, 0, 0, 0));
		send_step(mk(KIND_INSTR, OP_ADD, 7, 1, 1, 0, 0, 0));
		send_step(mk(KIND_INSTR, OP_SUB, 8, 1, 0, 0, 0, 0));
		send_step(mk(KIND_INSTR, OP_ADD, 9, 1, 1, 0, 0, 0));
		send_step(mk(KIND_LOAD_REG, OP_ADD, 0, 0, 0, 0, 4, 5));
		repeat (8) send_step(mk(KIND_STEP, OP_ADD, 0, 0, 0, 0, 0, 0));
		for (n = 0; n < 1330; n++) begin
			if (n == 400)
				req_gap_pct = 0;
			if (n == 600)
				req_gap_pct = 13;
			send_step(rand_step());
		end
		req.valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (arst_n);
		repeat (300) @(posedge clk);
		rsp_gap_pct = 0;
		repeat (200) @(posedge clk);
		hold_off = 1;
		repeat (60) @(posedge clk);
		hold_off = 0;
		repeat (200) @(posedge clk);
		rsp_gap_pct = 13;
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
